>>> rtl/weighted_random_server_picker_core_macros.svh
// Assertion macros for the server picker checker.
`ifndef WEIGHTED_RANDOM_SERVER_PICKER_CORE_MACROS_SVH
`define WEIGHTED_RANDOM_SERVER_PICKER_CORE_MACROS_SVH
// Check an implication at every clock edge outside reset.
`define WRSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Check a next-cycle implication outside reset.
`define WRSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

>>> rtl/wrsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsp_pkg
// Shared types and constants of the weighted random server picker.
// ----------------------------------------------------------------------------
package wrsp_pkg;
  localparam int MAX_ENTRIES = 16;
  localparam int GROUPS_PER_CLUSTER = 8;
  localparam int CLUSTERS = 4;
  localparam int SUM_SLOTS = CLUSTERS * GROUPS_PER_CLUSTER;
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = (SUM_SLOTS > 1) ? $clog2(SUM_SLOTS) : 1;
  localparam int CLW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int IDXW = 4;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0, REQ_PICK = 2'd1, REQ_RESET = 2'd2, REQ_MASTER = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_RANGE = 2'd2, ST_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] group;
    logic [7:0] cluster;
    logic [6:0] cs_w;
    logic [6:0] ms_w;
    logic       master;
  } entry_t;

  typedef struct packed {
    logic [15:0] weight_sum;
    logic [8:0]  master_cluster;
    logic [3:0]  entry_index;
    logic        found;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [30:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction
endpackage

>>> rtl/wrsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsp_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrsp_div import wrsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [15:0] rem
);
  logic [30:0] dvd;
  logic [15:0] dvs;
  logic [16:0] acc;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] sh;

  assign sh  = {acc[15:0], dvd[30]};
  assign rem = acc[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        acc  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        acc <= (sh >= {1'b0, dvs}) ? sh - {1'b0, dvs} : sh;
        dvd <= {dvd[29:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/wrsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsp_ram
// Generic single-write, single-read synchronous RAM.
// ----------------------------------------------------------------------------
module wrsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/weighted_random_server_picker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_random_server_picker_core
// Server table with per cluster/group weight sums and weighted picking.
// ----------------------------------------------------------------------------
// One request is worked on at a time; its result beat waits in an output
// register, so the next request is taken while the receiver stalls. A load
// checks its bounds and the table fill, then writes the entry and adds its
// weights into both sum memories; a rejected load skips the write. A
// first-entry load first clears the sum memories one slot a cycle. A pick
// reads its sums for one cluster or for each cluster in turn, runs the
// bit-serial remainder unit and walks the table entry by entry, stopping at
// the first match; a zero sum skips the remainder and the walk. A master
// lookup walks the whole table, and a weight reset walks it too, with a
// further read and write for each entry of the group. After reset the sum
// memories are cleared before the first request is taken.
module weighted_random_server_picker_core import wrsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: req_type, first_entry, group_id, cluster, server_kind, ms_weight,
  //        cs_weight, is_master, random_value, zero pad (bits 67..71)
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: status, found, entry_index, master_cluster, weight_sum
  output logic [31:0] m_tdata
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_PK_RD, S_PK_ACC, S_PK_DIV,
    S_WK_RD, S_WK_CHK, S_RS_SUM, S_RS_WR, S_OUT
  } state_t;

  state_t state, state_next;

  logic [1:0]  req;
  logic        first_q, kind;
  logic [7:0]  grp;
  logic [8:0]  cl;
  logic [6:0]  msw, csw;
  logic        mst;
  logic [30:0] rnd;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [SW-1:0] clr_addr;
  logic [CLW:0]  cidx;
  logic [15:0]   wsum, rmod;
  logic [16:0]   total;
  result_t       res;
  result_t       out_data;
  logic          out_valid;

  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  entry_t        e_wdata, e_rdata;
  logic          c_we, m_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [15:0]   c_wdata, m_wdata, c_rdata, m_rdata;

  div_req_t    dreq;
  logic        ddone;
  logic [15:0] drem;

  wrsp_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ENTRIES)) u_entries (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata));
  wrsp_ram #(.WIDTH(16), .DEPTH(SUM_SLOTS)) u_csums (
    .clk(clk), .we(c_we), .waddr(s_waddr), .wdata(c_wdata),
    .raddr(s_raddr), .rdata(c_rdata));
  wrsp_ram #(.WIDTH(16), .DEPTH(SUM_SLOTS)) u_msums (
    .clk(clk), .we(m_we), .waddr(s_waddr), .wdata(m_wdata),
    .raddr(s_raddr), .rdata(m_rdata));
  wrsp_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .rem(drem));

  logic grp_ok, cl_ok_ld, cl_ok_pk;
  logic [SW-1:0] slot_ld;
  logic [15:0] ksum;
  logic [15:0] wsum_acc;
  logic [6:0]  ew;
  logic        ematch;

  assign grp_ok   = grp < 8'(GROUPS_PER_CLUSTER);
  assign cl_ok_ld = !cl[8] && (cl < 9'(CLUSTERS));
  assign cl_ok_pk = cl_ok_ld || (cl == 9'h1FF);
  assign slot_ld  = SW'(cl * 9'(GROUPS_PER_CLUSTER) + 9'(grp));
  assign ksum     = kind ? m_rdata : c_rdata;
  assign wsum_acc = cl[8] ? sat_add(wsum, ksum) : ksum;
  assign ew       = kind ? e_rdata.ms_w : e_rdata.cs_w;
  assign ematch   = (e_rdata.group == grp) &&
                    (cl[8] || e_rdata.cluster == cl[7:0]);

  assign s_tready = (state == S_IDLE) && !first_q;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    state_next = state;
    e_we = 1'b0; e_waddr = count[EW-1:0]; e_raddr = idx[EW-1:0];
    if (state == S_WK_CHK || state == S_RS_SUM || state == S_RS_WR)
      e_raddr = idx[EW-1:0] - EW'(1);
    e_wdata = '{group: grp, cluster: cl[7:0], cs_w: csw, ms_w: msw, master: mst};
    c_we = 1'b0; m_we = 1'b0; s_waddr = slot_ld; s_raddr = slot_ld;
    c_wdata = sat_add(c_rdata, {9'd0, csw});
    m_wdata = sat_add(m_rdata, {9'd0, msw});
    dreq = '{start: 1'b0, dividend: rnd, divisor: wsum};
    if (state == S_PK_RD || state == S_PK_ACC) begin
      s_raddr = SW'(cidx[CLW-1:0] * GROUPS_PER_CLUSTER + 32'(grp));
      if (!cl[8]) s_raddr = slot_ld;
    end
    if (state == S_RS_SUM || state == S_RS_WR) begin
      s_raddr = SW'(32'(e_rdata.cluster) * GROUPS_PER_CLUSTER + 32'(grp));
      s_waddr = s_raddr;
      c_wdata = sat_add(c_rdata, 16'd1);
      m_wdata = sat_add(m_rdata, 16'd1);
    end
    unique case (state)
      S_CLEAR: begin
        c_we = 1'b1; m_we = 1'b1; s_waddr = clr_addr;
        c_wdata = '0; m_wdata = '0;
        if (clr_addr == SW'(SUM_SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          if (s_tdata[1:0] == REQ_LOAD && s_tdata[2]) state_next = S_CLEAR;
          else if (s_tdata[1:0] == REQ_LOAD) state_next = S_LD_RD;
          else if (s_tdata[1:0] == REQ_PICK) state_next = S_PK_RD;
          else state_next = S_WK_RD;
        end else if (first_q) begin
          state_next = S_LD_RD;
        end
      end
      S_LD_RD: begin
        if (!grp_ok || !cl_ok_ld || count >= CW'(MAX_ENTRIES)) state_next = S_OUT;
        else state_next = S_LD_WR;
      end
      S_LD_WR: begin
        e_we = 1'b1; c_we = 1'b1; m_we = 1'b1;
        state_next = S_OUT;
      end
      S_PK_RD: begin
        if (!grp_ok || !cl_ok_pk) state_next = S_OUT;
        else state_next = S_PK_ACC;
      end
      S_PK_ACC: begin
        if (cl[8] && cidx != (CLW+1)'(CLUSTERS)) state_next = S_PK_ACC;
        else begin
          dreq.start = (wsum_acc != 16'd0);
          dreq.divisor = wsum_acc;
          state_next = (wsum_acc != 16'd0) ? S_PK_DIV : S_OUT;
        end
      end
      S_PK_DIV: if (ddone) state_next = S_WK_RD;
      S_WK_RD: begin
        if ((req == REQ_RESET || req == REQ_MASTER) && !grp_ok) state_next = S_OUT;
        else if (idx >= count) state_next = S_OUT;
        else state_next = S_WK_CHK;
      end
      S_WK_CHK: begin
        if (req == REQ_PICK && ematch && (17'(rmod) < total + 17'(ew)) && ew != 0)
          state_next = S_OUT;
        else if (req == REQ_RESET && e_rdata.group == grp) state_next = S_RS_SUM;
        else state_next = S_WK_RD;
      end
      S_RS_SUM: state_next = S_RS_WR;
      S_RS_WR: begin
        e_we = 1'b1; e_waddr = idx[EW-1:0] - EW'(1);
        e_wdata = e_rdata;
        if (kind) e_wdata.ms_w = 7'd1; else e_wdata.cs_w = 7'd1;
        c_we = !kind; m_we = kind;
        state_next = S_WK_RD;
      end
      S_OUT: begin
        if (!out_valid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      count <= '0;
      out_valid <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
        out_data <= res;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SW'(1);
          count <= '0;
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            {rnd, mst, csw, msw, kind, cl, grp} <= s_tdata[66:3];
            req <= s_tdata[1:0];
            first_q <= s_tdata[2] && s_tdata[1:0] == REQ_LOAD;
            clr_addr <= '0;
            idx <= '0; cidx <= '0; wsum <= '0; total <= '0;
            res <= '{status: ST_OK, found: 1'b0, entry_index: '0,
                     master_cluster: 9'h1FF, weight_sum: '0};
          end else begin
            first_q <= 1'b0;
          end
        end
        S_LD_RD: begin
          if (!grp_ok || !cl_ok_ld) res.status <= ST_RANGE;
          else if (count >= CW'(MAX_ENTRIES)) res.status <= ST_FULL;
        end
        S_LD_WR: count <= count + CW'(1);
        S_PK_RD: begin
          if (!grp_ok || !cl_ok_pk) res.status <= ST_RANGE;
          else res.status <= ST_NONE;
          cidx <= cidx + 1'b1;
        end
        S_PK_ACC: begin
          wsum <= wsum_acc;
          res.weight_sum <= wsum_acc;
          cidx <= cidx + 1'b1;
        end
        S_PK_DIV: rmod <= drem;
        S_WK_RD: begin
          if (req == REQ_RESET && !grp_ok) res.status <= ST_RANGE;
          if (req == REQ_MASTER && !grp_ok) res.status <= ST_RANGE;
          else if (req == REQ_MASTER && idx == '0 && !res.found) res.status <= ST_NONE;
          if (idx < count) idx <= idx + CW'(1);
        end
        S_WK_CHK: begin
          if (req == REQ_PICK && ematch) begin
            total <= total + 17'(ew);
            if ((17'(rmod) < total + 17'(ew)) && ew != 0) begin
              res.status <= ST_OK; res.found <= 1'b1;
              res.entry_index <= IDXW'(idx - CW'(1));
            end
          end
          if (req == REQ_MASTER && e_rdata.group == grp && e_rdata.master) begin
            res.status <= ST_OK; res.found <= 1'b1;
            res.master_cluster <= {1'b0, e_rdata.cluster};
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/wrsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsp_checker
// Port-level checks of the server picker, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_random_server_picker_core_macros.svh"
module wrsp_checker import wrsp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  `WRSP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `WRSP_ASSERT_IMP(a_found_ok, m_tvalid && m_tdata[2], m_tdata[1:0] == ST_OK)
  `WRSP_ASSERT_IMP(a_idx_clean, m_tvalid && !m_tdata[2], m_tdata[6:3] == 4'd0)
  `WRSP_ASSERT_NEXT(a_one_take, s_tvalid && s_tready, !s_tready)
endmodule

bind weighted_random_server_picker_core wrsp_checker u_chk (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Server picker stream test
// Loads, picks, weight resets and master lookups go in through the input
// stream; a local model of the table and the weight sums predicts each result
// beat, which is compared field by field as it leaves the output stream.
// ----------------------------------------------------------------------------
module testbench;
  import wrsp_pkg::*;

  typedef struct packed {
    logic [30:0] rnd;
    logic        mst;
    logic [6:0]  csw;
    logic [6:0]  msw;
    logic        kind;
    logic [8:0]  cl;
    logic [7:0]  grp;
    logic        first;
    logic [1:0]  req;
  } beat_t;

  typedef struct {
    int unsigned grp;
    int unsigned cl;
    int unsigned csw;
    int unsigned msw;
    bit          mst;
  } server_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic [71:0] s_tdata = '0;
  logic s_tready, m_tvalid;
  logic [31:0] m_tdata;

  weighted_random_server_picker_core uut (.*);

  initial forever #2 clk = ~clk;

  beat_t       pending_beats[$];
  result_t     expected_results[$];
  server_t     servers[MAX_ENTRIES];
  int unsigned server_count;
  logic [15:0] chunk_sums[SUM_SLOTS];
  logic [15:0] merge_sums[SUM_SLOTS];
  int errors = 0;
  bit stimulus_done = 0;
  int hold_off = 0;
  int taken = 0;
  int idle_cycles = 0;

  function automatic logic [15:0] sum_sat(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = a + b;
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void clear_table();
    server_count = 0;
    foreach (chunk_sums[i]) begin
      chunk_sums[i] = 0;
      merge_sums[i] = 0;
    end
  endfunction

  function automatic result_t predict_result(beat_t b);
    result_t r;
    int cl;
    int unsigned s, rv, total, w;
    bit grp_ok;
    r = '{status: ST_OK, found: 0, entry_index: 0, master_cluster: 9'h1FF, weight_sum: 0};
    cl = $signed(b.cl);
    grp_ok = b.grp < GROUPS_PER_CLUSTER;
    case (req_t'(b.req))
      REQ_LOAD: begin
        if (b.first) clear_table();
        if (!grp_ok || cl < 0 || cl >= CLUSTERS) r.status = ST_RANGE;
        else if (server_count >= MAX_ENTRIES) r.status = ST_FULL;
        else begin
          s = cl * GROUPS_PER_CLUSTER + b.grp;
          servers[server_count] = '{b.grp, cl, b.csw, b.msw, b.mst};
          server_count++;
          chunk_sums[s] = sum_sat(chunk_sums[s], 16'(b.csw));
          merge_sums[s] = sum_sat(merge_sums[s], 16'(b.msw));
        end
      end
      REQ_PICK: begin
        if (!grp_ok || cl < -1 || cl >= CLUSTERS) r.status = ST_RANGE;
        else begin
          for (int c = 0; c < CLUSTERS; c++)
            if (cl < 0 || c == cl)
              r.weight_sum = sum_sat(r.weight_sum, b.kind ?
                merge_sums[c*GROUPS_PER_CLUSTER+b.grp] : chunk_sums[c*GROUPS_PER_CLUSTER+b.grp]);
          r.status = ST_NONE;
          if (r.weight_sum != 0) begin
            rv = b.rnd % r.weight_sum;
            total = 0;
            for (int i = 0; i < server_count; i++)
              if (servers[i].grp == b.grp && (cl < 0 || servers[i].cl == cl)) begin
                w = b.kind ? servers[i].msw : servers[i].csw;
                total += w;
                if (rv < total && w > 0) begin
                  r.status = ST_OK;
                  r.found = 1;
                  r.entry_index = 4'(i);
                  break;
                end
              end
          end
        end
      end
      REQ_RESET: begin
        if (!grp_ok) r.status = ST_RANGE;
        else
          for (int i = 0; i < server_count; i++)
            if (servers[i].grp == b.grp) begin
              s = servers[i].cl * GROUPS_PER_CLUSTER + servers[i].grp;
              if (b.kind) begin
                servers[i].msw = 1;
                merge_sums[s] = sum_sat(merge_sums[s], 16'd1);
              end else begin
                servers[i].csw = 1;
                chunk_sums[s] = sum_sat(chunk_sums[s], 16'd1);
              end
            end
      end
      default: begin
        if (!grp_ok) r.status = ST_RANGE;
        else begin
          r.status = ST_NONE;
          for (int i = 0; i < server_count; i++)
            if (servers[i].grp == b.grp && servers[i].mst) begin
              r.status = ST_OK;
              r.found = 1;
              r.master_cluster = 9'(servers[i].cl);
            end
        end
      end
    endcase
    return r;
  endfunction

  function automatic beat_t make_beat(req_t req, bit first, int grp, int cl, bit kind,
                                      int msw, int csw, bit mst, int unsigned rnd);
    beat_t b;
    b.req = req;
    b.first = first;
    b.grp = 8'(grp);
    b.cl = 9'(cl);
    b.kind = kind;
    b.msw = 7'(msw);
    b.csw = 7'(csw);
    b.mst = mst;
    b.rnd = 31'(rnd);
    return b;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int sel;
    b = 67'({$urandom, $urandom, $urandom});
    sel = $urandom_range(0, 99);
    if (sel < 90) begin
      b.grp = 8'($urandom_range(0, GROUPS_PER_CLUSTER - 1));
      b.cl = ($urandom_range(0, 9) == 0) ? 9'h1FF : 9'($urandom_range(0, CLUSTERS - 1));
    end
    if (sel < 40) begin
      b.req = REQ_LOAD;
      b.first = $urandom_range(0, 29) == 0;
      if (b.cl == 9'h1FF) b.cl = 0;
    end else if (sel < 75) b.req = REQ_PICK;
    else if (sel < 85) b.req = REQ_MASTER;
    else if (sel < 90) b.req = REQ_RESET;
    return b;
  endfunction

  // sender: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        void'(pending_beats.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 0;
      end else if (burst_left == 0 && !(s_tvalid && !s_tready)) begin
        burst_left = $urandom_range(1, 12);
        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
        s_tvalid <= 0;
      end else if (pending_beats.size() != 0) begin
        s_tvalid <= 1;
        s_tdata <= {5'b0, pending_beats[0]};
      end else s_tvalid <= 0;
    end
  end

  // receiver: own stall pattern and one long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else begin
      if (m_tvalid && m_tready) taken <= taken + 1;
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 0;
      end else if (m_tvalid && m_tready && taken == 300) begin
        hold_off <= 3000;
        m_tready <= 0;
      end else m_tready <= ($urandom_range(0, 3) != 0) || stimulus_done;
    end
  end

  // checker
  always @(posedge clk) begin
    result_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp = expected_results.pop_front();
        if (got.status !== exp.status)
          $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        if (got.found !== exp.found)
          $display("%0t: found exp %0d got %0d", $time, exp.found, got.found);
        if (got.entry_index !== exp.entry_index)
          $display("%0t: entry_index exp %0d got %0d", $time, exp.entry_index,
                   got.entry_index);
        if (got.master_cluster !== exp.master_cluster)
          $display("%0t: master_cluster exp %h got %h", $time, exp.master_cluster,
                   got.master_cluster);
        if (got.weight_sum !== exp.weight_sum)
          $display("%0t: weight_sum exp %0d got %0d", $time, exp.weight_sum,
                   got.weight_sum);
        if (got !== exp) errors++;
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) expected_results.push_back(predict_result(s_tdata[66:0]));
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    clear_table();
    repeat (2) @(posedge clk);
    rst <= 0;
    // directed
    pending_beats.push_back(make_beat(REQ_PICK, 0, 0, 0, 0, 0, 0, 0, 5));
    pending_beats.push_back(make_beat(REQ_MASTER, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_LOAD, 1, 0, 0, 0, 127, 127, 1, 0));
    pending_beats.push_back(make_beat(REQ_LOAD, 0, 0, 3, 1, 0, 0, 1, 0));
    pending_beats.push_back(make_beat(REQ_LOAD, 0, 7, 1, 0, 5, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_LOAD, 0, 8, 0, 0, 1, 1, 0, 0));
    pending_beats.push_back(make_beat(REQ_LOAD, 0, 255, 9'h1FF, 0, 1, 1, 0, 0));
    pending_beats.push_back(make_beat(REQ_LOAD, 0, 0, 4, 0, 1, 1, 0, 0));
    pending_beats.push_back(make_beat(REQ_LOAD, 1, 0, 255, 0, 1, 1, 0, 0));
    pending_beats.push_back(make_beat(REQ_LOAD, 0, 0, 0, 0, 127, 127, 1, 0));
    pending_beats.push_back(make_beat(REQ_LOAD, 0, 0, 2, 0, 0, 3, 0, 0));
    for (int i = 0; i < 15; i++)
      pending_beats.push_back(make_beat(REQ_LOAD, 0, 1, i % CLUSTERS, 0, 127, 127, i[0], 0));
    pending_beats.push_back(make_beat(REQ_PICK, 0, 0, 9'h1FF, 0, 0, 0, 0, 31'h7FFFFFFF));
    pending_beats.push_back(make_beat(REQ_PICK, 0, 0, 0, 1, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_PICK, 0, 7, 1, 0, 0, 0, 0, 3));
    pending_beats.push_back(make_beat(REQ_PICK, 0, 8, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_PICK, 0, 0, 9'h1FE, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_PICK, 0, 0, 4, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_RESET, 0, 1, 0, 1, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_RESET, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_RESET, 0, 200, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_MASTER, 0, 1, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_MASTER, 0, 5, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(REQ_MASTER, 0, 128, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 1100; i++)
      pending_beats.push_back(random_beat());
    while (pending_beats.size() != 0) @(posedge clk);
    stimulus_done = 1;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
